@@ rtl/icc_pkg.sv @@
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types, style codes and ASCII helpers for the case converter.
// ----------------------------------------------------------------------------
package icc_pkg;

	localparam int CHAR_W      = 21;
	localparam int SEP_W       = 7;
	localparam int MODE_W      = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// style codes
	localparam logic [MODE_W-1:0] MODE_DEFAULT     = 5'd0;
	localparam logic [MODE_W-1:0] MODE_CAMEL       = 5'd1;
	localparam logic [MODE_W-1:0] MODE_CAPITAL     = 5'd2;
	localparam logic [MODE_W-1:0] MODE_CONSTANT    = 5'd3;
	localparam logic [MODE_W-1:0] MODE_DOT         = 5'd4;
	localparam logic [MODE_W-1:0] MODE_HEADER      = 5'd5;
	localparam logic [MODE_W-1:0] MODE_NO          = 5'd6;
	localparam logic [MODE_W-1:0] MODE_PARAM       = 5'd7;
	localparam logic [MODE_W-1:0] MODE_PASCAL      = 5'd8;
	localparam logic [MODE_W-1:0] MODE_PATH        = 5'd9;
	localparam logic [MODE_W-1:0] MODE_SENTENCE    = 5'd10;
	localparam logic [MODE_W-1:0] MODE_SNAKE       = 5'd11;
	localparam logic [MODE_W-1:0] MODE_TITLE       = 5'd12;
	localparam logic [MODE_W-1:0] MODE_SWAP        = 5'd13;
	localparam logic [MODE_W-1:0] MODE_LOWER       = 5'd14;
	localparam logic [MODE_W-1:0] MODE_LOWER_FIRST = 5'd15;
	localparam logic [MODE_W-1:0] MODE_UPPER       = 5'd16;
	localparam logic [MODE_W-1:0] MODE_UPPER_FIRST = 5'd17;
	localparam logic [MODE_W-1:0] MODE_SPONGE      = 5'd18;

	localparam logic [SEP_W-1:0] CH_SPACE = 7'h20;
	localparam logic [SEP_W-1:0] CH_TAB   = 7'h09;
	localparam logic [SEP_W-1:0] CH_DOT   = 7'h2E;
	localparam logic [SEP_W-1:0] CH_UNDER = 7'h5F;
	localparam logic [SEP_W-1:0] CH_SLASH = 7'h2F;
	localparam logic [SEP_W-1:0] CH_DASH  = 7'h2D;
	localparam logic [SEP_W-1:0] CH_NUL   = 7'h00;
	localparam logic [CHAR_W-1:0] CASE_OFS = 21'd32;

	// one queued piece of work: optional separator, optional character
	typedef struct packed {
		logic              has_sep;
		logic              has_chr;
		logic [SEP_W-1:0]  sep;
		logic [CHAR_W-1:0] chr;
	} entry_t;

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return c == {14'd0, CH_SPACE} || c == {14'd0, CH_TAB} || c == {14'd0, CH_DOT} ||
		       c == {14'd0, CH_UNDER} || c == {14'd0, CH_SLASH} || c == {14'd0, CH_DASH};
	endfunction

	function automatic logic is_low(input logic [CHAR_W-1:0] c);
		return c >= 21'h61 && c <= 21'h7A;
	endfunction

	function automatic logic is_up(input logic [CHAR_W-1:0] c);
		return c >= 21'h41 && c <= 21'h5A;
	endfunction

	function automatic logic [CHAR_W-1:0] to_up(input logic [CHAR_W-1:0] c);
		return is_low(c) ? c - CASE_OFS : c;
	endfunction

	function automatic logic [CHAR_W-1:0] to_low(input logic [CHAR_W-1:0] c);
		return is_up(c) ? c + CASE_OFS : c;
	endfunction

endpackage

@@ rtl/identifier_case_converter_core.sv @@
// ----------------------------------------------------------------------------
// identifier_case_converter_core
// Streams code points, splits them into words and rewrites them in a style.
// ----------------------------------------------------------------------------
// One character is accepted per cycle while the four-entry work queue has
// room. Each character yields zero, one or two output transactions; the back
// end sends one per cycle while m_tready is high, a word separator ahead of
// the character that starts the new word. tuser on the input marks the start
// of a string and clears the word state. tlast on the output marks the final
// transaction a character caused. The user must write the style register via
// cfg_we/cfg_wdata only while the stream is idle; the block does not check it.
module identifier_case_converter_core
	import icc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,     // case_mode
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,       // [20:0] in_char, rest zero
	input  logic [0:0]        s_tuser,       // [0] string_start
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,       // [20:0] out_char, rest zero
	output logic              m_tlast        // last_of_run
);

	logic              full, empty, push, pop, accept;
	entry_t            push_entry, head;
	logic [CHAR_W-1:0] out_char;

	assign s_tready = ~full;
	assign accept   = s_tvalid & s_tready;
	assign m_tdata  = {3'b000, out_char};

	icc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.in_char      (s_tdata[CHAR_W-1:0]),
		.string_start (s_tuser[0]),
		.push         (push),
		.push_entry   (push_entry)
	);

	icc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	icc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

endmodule

@@ rtl/icc_front.sv @@
// ----------------------------------------------------------------------------
// icc_front
// Accepts characters, tracks word state and builds the queued work entry.
// ----------------------------------------------------------------------------
module icc_front
	import icc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	input  logic              accept,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              string_start,
	output logic              push,
	output entry_t            push_entry
);

	logic [MODE_W-1:0] mode_q;
	logic              prev_low_q, written_q, odd_q, word_start_q;

	logic              pl, wr, od, ws, ws_chr, bnd, dflt, sep_in;
	logic              n_pl, n_wr, n_od, n_ws;
	logic [SEP_W-1:0]  sep_code;
	logic [CHAR_W-1:0] wcap, conv;

	always_comb begin
		pl   = string_start ? 1'b0 : prev_low_q;
		wr   = string_start ? 1'b0 : written_q;
		od   = string_start ? 1'b0 : odd_q;
		ws   = string_start ? 1'b1 : word_start_q;
		dflt = (mode_q == MODE_DEFAULT) || (mode_q > MODE_SPONGE);
		sep_in = is_sep(in_char);
		bnd  = pl & is_up(in_char);
		ws_chr = bnd | ws;

		// separator emitted at a word boundary, zero when suppressed
		case (mode_q)
			MODE_CAMEL:    sep_code = wr ? CH_NUL : CH_SPACE;
			MODE_CONSTANT: sep_code = CH_UNDER;
			MODE_DOT:      sep_code = CH_DOT;
			MODE_HEADER:   sep_code = CH_DASH;
			MODE_PARAM:    sep_code = CH_DASH;
			MODE_PASCAL:   sep_code = CH_NUL;
			MODE_PATH:     sep_code = CH_SLASH;
			MODE_SNAKE:    sep_code = CH_UNDER;
			default:       sep_code = CH_SPACE;
		endcase

		wcap = ws_chr ? to_up(in_char) : to_low(in_char);
		case (mode_q)
			MODE_CAMEL:       conv = wr ? wcap : to_low(in_char);
			MODE_CAPITAL:     conv = wcap;
			MODE_CONSTANT:    conv = to_up(in_char);
			MODE_DOT:         conv = in_char;
			MODE_HEADER:      conv = wcap;
			MODE_NO:          conv = to_low(in_char);
			MODE_PARAM:       conv = to_low(in_char);
			MODE_PASCAL:      conv = wcap;
			MODE_PATH:        conv = in_char;
			MODE_SENTENCE:    conv = wr ? to_low(in_char) : to_up(in_char);
			MODE_SNAKE:       conv = to_low(in_char);
			MODE_TITLE:       conv = wcap;
			MODE_SWAP:        conv = is_low(in_char) ? to_up(in_char) : to_low(in_char);
			MODE_LOWER:       conv = to_low(in_char);
			MODE_LOWER_FIRST: conv = wr ? in_char : to_low(in_char);
			MODE_UPPER:       conv = to_up(in_char);
			MODE_UPPER_FIRST: conv = wr ? in_char : to_up(in_char);
			MODE_SPONGE:      conv = od ? to_low(in_char) : to_up(in_char);
			default:          conv = in_char;
		endcase

		n_pl = pl;
		n_wr = wr;
		n_od = od;
		n_ws = ws;
		push_entry.sep = sep_code;
		push_entry.chr = in_char;
		push_entry.has_sep = 1'b0;
		push_entry.has_chr = 1'b0;
		if (dflt) begin
			push_entry.has_chr = 1'b1;
		end else if (sep_in) begin
			// leading separator of a string leaves only the cleared state
			if (!string_start) begin
				push_entry.has_sep = (sep_code != CH_NUL);
				n_ws = 1'b1;
				n_pl = 1'b0;
			end
		end else begin
			push_entry.has_sep = bnd && (sep_code != CH_NUL);
			push_entry.has_chr = 1'b1;
			push_entry.chr = conv;
			n_pl = is_low(in_char);
			n_wr = 1'b1;
			n_od = ~od;
			n_ws = 1'b0;
		end
		push = accept & (push_entry.has_sep | push_entry.has_chr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DEFAULT;
			prev_low_q   <= 1'b0;
			written_q    <= 1'b0;
			odd_q        <= 1'b0;
			word_start_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				prev_low_q   <= n_pl;
				written_q    <= n_wr;
				odd_q        <= n_od;
				word_start_q <= n_ws;
			end
		end
	end

endmodule

@@ rtl/icc_queue.sv @@
// ----------------------------------------------------------------------------
// icc_queue
// Small register queue of work entries between front and back.
// ----------------------------------------------------------------------------
module icc_queue
	import icc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/icc_back.sv @@
// ----------------------------------------------------------------------------
// icc_back
// Expands each queued entry into one or two output transactions.
// ----------------------------------------------------------------------------
module icc_back
	import icc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_last
);

	logic sep_done_q;
	logic show_sep;

	assign show_sep  = head.has_sep & ~sep_done_q;
	assign out_valid = ~empty;
	assign out_char  = show_sep ? {{(CHAR_W-SEP_W){1'b0}}, head.sep} : head.chr;
	assign out_last  = ~show_sep | ~head.has_chr;
	assign pop       = out_valid & out_ready & out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_done_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			// hold the entry for its character after the separator goes out
			sep_done_q <= ~out_last;
		end
	end

endmodule
